[hdl/cfsc_pkg.sv]
// shared types and constants of the can frame sequence checker
package cfsc_pkg;

  localparam int unsigned MaxFrameBytesDefault = 64;
  localparam logic [31:0] MagicReset = 32'h0C5F_D504;
  localparam logic [7:0]  PatternBase = 8'hA5;
  localparam int unsigned HeaderBytes = 8;
  localparam int unsigned PatternStart = 12;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW = 7;
  localparam int unsigned IdxW = 7;
  localparam int unsigned CntW = 32;
  localparam int unsigned InDataW = 16;
  localparam int unsigned OutDataW = 232;
  localparam int unsigned AddrW = 3;

  // register index carried in paddr[2]
  localparam logic CfgIdxMagic = 1'b0;

  localparam logic [1:0] StatusUnchecked = 2'd0;
  localparam logic [1:0] StatusGood = 2'd1;
  localparam logic [1:0] StatusContentErr = 2'd2;

  typedef struct packed {
    logic            valid;
    logic [LenW-1:0] len;
    logic            checked;
    logic            bad;
    logic [CntW-1:0] seq;
    logic [CntW-1:0] gap_delta;
  } frame_sum_t;

endpackage

[hdl/cfsc_frame_track.sv]
// per-frame byte tracking: header capture, pattern check and sequence gap
module cfsc_frame_track #(
  parameter int unsigned MAX_FRAME_BYTES = cfsc_pkg::MaxFrameBytesDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      in_valid_i,
  input  logic [cfsc_pkg::ByteW-1:0] in_byte_i,
  input  logic [cfsc_pkg::LenW-1:0] in_len_i,
  input  logic                      in_last_i,
  input  logic [31:0]               expected_magic_i,
  output cfsc_pkg::frame_sum_t      sum_o
);
  import cfsc_pkg::*;

  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_FRAME_BYTES);
  localparam logic [IdxW-1:0] IdxSat = '1;

  logic [IdxW-1:0] idx_q, idx_d;
  logic [31:0]     magic_q, magic_d;
  logic [31:0]     seq_q, seq_d;
  logic            bad_q, bad_d;
  logic [31:0]     expect_q, expect_d;
  logic            have_q, have_d;
  frame_sum_t      sum_q, sum_d;

  logic [LenW-1:0] len;
  logic            last;
  logic            checked;
  logic [31:0]     diff;
  logic            seq_greater;
  logic [7:0]      want;

  always_comb begin
    len = (in_len_i > MaxLen) ? MaxLen : in_len_i;
    last = in_last_i || (len == '0);
    want = PatternBase ^ {1'b0, idx_q} ^ seq_q[7:0];

    idx_d = idx_q;
    magic_d = magic_q;
    seq_d = seq_q;
    bad_d = bad_q;
    expect_d = expect_q;
    have_d = have_q;
    sum_d = sum_q;
    sum_d.valid = 1'b0;

    if (len != '0) begin
      if (idx_q < len) begin
        if (idx_q < IdxW'(4)) begin
          magic_d[8*idx_q[1:0] +: 8] = in_byte_i;
        end else if (idx_q < IdxW'(HeaderBytes)) begin
          seq_d[8*idx_q[1:0] +: 8] = in_byte_i;
        end else if (idx_q >= IdxW'(PatternStart)) begin
          if (in_byte_i != want) begin
            bad_d = 1'b1;
          end
        end
      end
      if (idx_q != IdxSat) begin
        idx_d = idx_q + IdxW'(1);
      end
    end

    checked = (len >= LenW'(HeaderBytes)) && (idx_d >= IdxW'(HeaderBytes)) &&
              (magic_d == expected_magic_i);
    diff = seq_d - expect_q;
    seq_greater = seq_d > expect_q;

    if (in_valid_i && last) begin
      sum_d.valid = 1'b1;
      sum_d.len = len;
      sum_d.checked = checked;
      sum_d.bad = bad_d;
      sum_d.seq = checked ? seq_d : '0;
      sum_d.gap_delta = '0;
      if (checked) begin
        if (have_q && (seq_d != expect_q)) begin
          sum_d.gap_delta = seq_greater ? diff : 32'd1;
        end
        expect_d = seq_d + 32'd1;
        have_d = 1'b1;
      end
      idx_d = '0;
      magic_d = '0;
      seq_d = '0;
      bad_d = 1'b0;
    end

    if (!in_valid_i) begin
      idx_d = idx_q;
      magic_d = magic_q;
      seq_d = seq_q;
      bad_d = bad_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      magic_q <= '0;
      seq_q <= '0;
      bad_q <= 1'b0;
      expect_q <= '0;
      have_q <= 1'b0;
      sum_q <= '0;
    end else if (adv_i) begin
      idx_q <= idx_d;
      magic_q <= magic_d;
      seq_q <= seq_d;
      bad_q <= bad_d;
      expect_q <= expect_d;
      have_q <= have_d;
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

[hdl/cfsc_stats.sv]
// running counters and the result register of the checker
module cfsc_stats (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  cfsc_pkg::frame_sum_t         sum_i,
  output logic                         valid_o,
  output logic [cfsc_pkg::OutDataW-1:0] data_o
);
  import cfsc_pkg::*;

  logic            valid_q;
  logic [1:0]      status_q, status_d;
  logic [CntW-1:0] seq_q;
  logic [CntW-1:0] frames_q, bytes_q, checked_q, unchecked_q, gap_q, content_q;

  always_comb begin
    if (!sum_i.checked) begin
      status_d = StatusUnchecked;
    end else if (sum_i.bad) begin
      status_d = StatusContentErr;
    end else begin
      status_d = StatusGood;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      status_q <= StatusUnchecked;
      seq_q <= '0;
      frames_q <= '0;
      bytes_q <= '0;
      checked_q <= '0;
      unchecked_q <= '0;
      gap_q <= '0;
      content_q <= '0;
    end else if (adv_i) begin
      valid_q <= sum_i.valid;
      if (sum_i.valid) begin
        status_q <= status_d;
        seq_q <= sum_i.seq;
        frames_q <= frames_q + CntW'(1);
        bytes_q <= bytes_q + CntW'(sum_i.len);
        checked_q <= checked_q + CntW'(sum_i.checked);
        unchecked_q <= unchecked_q + CntW'(!sum_i.checked);
        gap_q <= gap_q + sum_i.gap_delta;
        content_q <= content_q + CntW'(sum_i.checked && sum_i.bad);
      end
    end
  end

  assign valid_o = valid_q;
  assign data_o = {6'd0, content_q, gap_q, unchecked_q, checked_q, bytes_q, frames_q,
                   seq_q, status_q};

endmodule

[hdl/can_frame_sequence_checker.sv]
// top level of the can test frame sequence checker
//
// input stream: one payload byte per request, each carrying the frame length,
// with tlast on the final byte; an item with length zero is an empty frame.
// output stream: one result per frame with the frame status, its sequence
// number and the six running counters as they stand after that frame.
// apb port: register 0 at address 0 holds the expected magic word; write it
// only while no frame is in flight.
// the path is three register stages (input, frame tracking, result); the
// input stage loads at the accepting edge, and the final byte passes the
// frame tracking and result registers in turn before its result appears;
// one byte is taken every cycle while the receiver keeps up.
// all stages move on one common enable: while a result sits unaccepted,
// s_axis_tready is low and everything holds; the result is held stable.
// reset clears the counters, the frame state and the sequence history and
// restores the magic word to its default.
module can_frame_sequence_checker #(
  parameter int unsigned MAX_FRAME_BYTES = cfsc_pkg::MaxFrameBytesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // payload_byte [7:0], frame_len [14:8], zero [15]
  input  logic [cfsc_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // frame_status [1:0], frame_seq [33:2], frames_total [65:34],
  // bytes_total [97:66], checked_total [129:98], unchecked_total [161:130],
  // gap_total [193:162], content_err_total [225:194], zero [231:226]
  output logic [cfsc_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cfsc_pkg::AddrW-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import cfsc_pkg::*;

  logic             adv;
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic [LenW-1:0]  in_len_q;
  logic             in_last_q;
  logic [31:0]      magic_q;
  frame_sum_t       sum;

  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CfgIdxMagic) ? magic_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= MagicReset;
    end else if (psel && penable && pwrite && (paddr[2] == CfgIdxMagic)) begin
      magic_q <= pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_byte_q <= s_axis_tdata[ByteW-1:0];
      in_len_q <= s_axis_tdata[ByteW +: LenW];
      in_last_q <= s_axis_tlast;
    end
  end

  cfsc_frame_track #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_track (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .in_valid_i      (in_valid_q),
    .in_byte_i       (in_byte_q),
    .in_len_i        (in_len_q),
    .in_last_i       (in_last_q),
    .expected_magic_i(magic_q),
    .sum_o           (sum)
  );

  cfsc_stats u_stats (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .sum_i  (sum),
    .valid_o(m_axis_tvalid),
    .data_o (m_axis_tdata)
  );

endmodule

[hdl/cfsc_checker.sv]
// port level checks of the can frame sequence checker, bound to the top level
module cfsc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [cfsc_pkg::OutDataW-1:0] m_axis_tdata
);
  import cfsc_pkg::*;

  // a stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // input is held off only by a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a pending result");

  // unchecked frames carry no sequence number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] == StatusUnchecked) |-> m_axis_tdata[33:2] == '0)
    else $error("unchecked frame with nonzero sequence");

  // every frame is either checked or unchecked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[129:98] + m_axis_tdata[161:130]) == m_axis_tdata[65:34])
    else $error("checked plus unchecked differs from frame count");

endmodule

bind can_frame_sequence_checker cfsc_checker u_cfsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
